[sv/psmrl_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the per-source mac rate limiter
// used by the channel interfaces, controller, datapath and top level

package psmrl_pkg;

    localparam int TABLE_ENTRIES = 512;
    localparam int ADDR_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam int MAC_W     = 48;
    localparam int LEN_W     = 16;
    localparam int TIME_W    = 64;
    localparam int TOK_W     = 16;
    localparam int OUTCOME_W = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 64;

    localparam logic [LEN_W-1:0]  MIN_FRAME_LEN = 16'd14;
    localparam logic [TIME_W-1:0] ONE_SEC_NS    = 64'd1000000000;
    localparam logic [TOK_W-1:0]  BUCKET_RESET  = 16'd10;
    localparam logic [TIME_W-1:0] WINDOW_RESET  = ONE_SEC_NS * 64'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REFILL_WINDOW = 1'b1;

    // outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_SPENT    = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_NEW      = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_REFILLED = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_FULL     = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_SHORT    = 3'd4;
    localparam logic [OUTCOME_W-1:0] OUT_LIMITED  = 3'd5;

    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [TOK_W-1:0]  tokens;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_NEW,
        WR_SPEND,
        WR_REFILL
    } wr_kind_t;

    typedef struct packed {
        logic                 load_in;
        logic                 rd_issue;
        logic                 cap_hit;
        wr_kind_t             wr_kind;
        logic                 set_res;
        logic                 res_pass;
        logic [OUTCOME_W-1:0] res_outcome;
        logic                 out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic short_frame;
        logic scan_end;
        logic mac_hit;
        logic table_full;
        logic tokens_zero;
        logic elapsed_gt;
        logic out_free;
    } dp_status_t;

endpackage

[sv/psmrl_in_if.sv]
`timescale 1ns / 1ps
// frame request channel: source mac, length and time stamp
// depends on psmrl_pkg for field widths

interface psmrl_in_if;
    import psmrl_pkg::*;

    logic              valid;
    logic              ready;
    logic [MAC_W-1:0]  source_mac;
    logic [LEN_W-1:0]  frame_length;
    logic [TIME_W-1:0] time_ns;

    modport source (output valid, output source_mac, output frame_length, output time_ns,
                    input ready);
    modport sink (input valid, input source_mac, input frame_length, input time_ns,
                  output ready);
endinterface

[sv/psmrl_out_if.sv]
`timescale 1ns / 1ps
// verdict channel: pass flag and outcome code per frame request
// depends on psmrl_pkg for field widths

interface psmrl_out_if;
    import psmrl_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 pass_frame;
    logic [OUTCOME_W-1:0] outcome;

    modport source (output valid, output pass_frame, output outcome, input ready);
    modport sink (input valid, input pass_frame, input outcome, output ready);
endinterface

[sv/psmrl_cfg_if.sv]
`timescale 1ns / 1ps
// configuration write channel: register index and write data
// depends on psmrl_pkg for field widths

interface psmrl_cfg_if;
    import psmrl_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[sv/psmrl_ram.sv]
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read data
// no dependencies

module psmrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[sv/psmrl_ctrl.sv]
`timescale 1ns / 1ps
// controller fsm: sequences accept, table scan, bucket update and result
// depends on psmrl_pkg for command and status types

module psmrl_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   frame_valid,
    output logic                   frame_ready,
    input  psmrl_pkg::dp_status_t  sts,
    output psmrl_pkg::ctrl_cmd_t   cmd
);
    import psmrl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_EVAL,
        S_MISS,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign frame_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd         = '0;
        cmd.wr_kind = WR_NONE;
        state_next  = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (frame_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.short_frame)
                begin
                    cmd.set_res     = 1'b1;
                    cmd.res_pass    = 1'b0;
                    cmd.res_outcome = OUT_SHORT;
                    state_next      = S_FINISH;
                end
                else if (sts.scan_end)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                // read data belongs to the address issued last cycle
                if (sts.mac_hit)
                begin
                    cmd.cap_hit = 1'b1;
                    state_next  = S_EVAL;
                end
                else if (sts.scan_end)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                end
            end
            S_EVAL:
            begin
                cmd.set_res = 1'b1;
                state_next  = S_FINISH;
                priority if (!sts.tokens_zero)
                begin
                    cmd.wr_kind     = WR_SPEND;
                    cmd.res_pass    = 1'b1;
                    cmd.res_outcome = OUT_SPENT;
                end
                else if (sts.elapsed_gt)
                begin
                    cmd.wr_kind     = WR_REFILL;
                    cmd.res_pass    = 1'b1;
                    cmd.res_outcome = OUT_REFILLED;
                end
                else
                begin
                    cmd.res_pass    = 1'b0;
                    cmd.res_outcome = OUT_LIMITED;
                end
            end
            S_MISS:
            begin
                cmd.set_res  = 1'b1;
                cmd.res_pass = 1'b1;
                state_next   = S_FINISH;
                if (sts.table_full)
                begin
                    cmd.res_outcome = OUT_FULL;
                end
                else
                begin
                    cmd.wr_kind     = WR_NEW;
                    cmd.res_outcome = OUT_NEW;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

[sv/psmrl_dp.sv]
`timescale 1ns / 1ps
// datapath: config registers, request registers, entry ram, scan counter,
// bucket arithmetic and verdict register; depends on psmrl_pkg and psmrl_ram

module psmrl_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  psmrl_pkg::ctrl_cmd_t                cmd,
    output psmrl_pkg::dp_status_t               sts,
    input  logic                                cfg_we,
    input  logic [psmrl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [psmrl_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  logic [psmrl_pkg::MAC_W-1:0]         source_mac,
    input  logic [psmrl_pkg::LEN_W-1:0]         frame_length,
    input  logic [psmrl_pkg::TIME_W-1:0]        time_ns,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                out_pass_frame,
    output logic [psmrl_pkg::OUTCOME_W-1:0]     out_outcome
);
    import psmrl_pkg::*;

    logic [TOK_W-1:0]     bucket_reg;
    logic [TIME_W-1:0]    window_reg;
    logic [CNT_W-1:0]     fill_reg;
    logic [CNT_W-1:0]     addr_reg;
    logic                 out_valid_reg;

    logic [MAC_W-1:0]     mac_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [TIME_W-1:0]    time_reg;
    logic [ADDR_W-1:0]    rd_addr_reg;
    logic [ADDR_W-1:0]    hit_addr_reg;
    logic [TOK_W-1:0]     tokens_reg;
    logic [TIME_W-1:0]    stamp_reg;
    logic [TIME_W-1:0]    elapsed_reg;
    logic                 res_pass_reg;
    logic [OUTCOME_W-1:0] res_outcome_reg;
    logic                 out_pass_reg;
    logic [OUTCOME_W-1:0] out_outcome_reg;

    entry_t               rd_entry;
    entry_t               wr_entry;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;

    psmrl_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .re    (cmd.rd_issue),
        .raddr (addr_reg[ADDR_W-1:0]),
        .rdata (rd_entry)
    );

    // entries below the fill count are valid; a new source always takes the next one
    always_comb
    begin
        wr_en           = 1'b1;
        wr_addr         = hit_addr_reg;
        wr_entry.mac    = mac_reg;
        wr_entry.tokens = tokens_reg - TOK_W'(1);
        wr_entry.stamp  = stamp_reg;
        unique case (cmd.wr_kind)
            WR_NONE:
            begin
                wr_en = 1'b0;
            end
            WR_NEW:
            begin
                wr_addr         = fill_reg[ADDR_W-1:0];
                wr_entry.tokens = bucket_reg;
                wr_entry.stamp  = time_reg;
            end
            WR_SPEND:
            begin
                wr_entry.tokens = tokens_reg - TOK_W'(1);
            end
            WR_REFILL:
            begin
                // spending saturates at zero
                wr_entry.tokens = (bucket_reg == '0) ? '0 : bucket_reg - TOK_W'(1);
                wr_entry.stamp  = time_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign sts.short_frame = (len_reg < MIN_FRAME_LEN);
    assign sts.scan_end    = (addr_reg == fill_reg);
    assign sts.mac_hit     = (rd_entry.mac == mac_reg);
    assign sts.table_full  = (fill_reg == CNT_W'(TABLE_ENTRIES));
    assign sts.tokens_zero = (tokens_reg == '0);
    assign sts.elapsed_gt  = (elapsed_reg > window_reg);
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign out_pass_frame = out_pass_reg;
    assign out_outcome    = out_outcome_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_reg    <= BUCKET_RESET;
            window_reg    <= WINDOW_RESET;
            fill_reg      <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BUCKET_SIZE:   bucket_reg <= cfg_data[TOK_W-1:0];
                    REG_REFILL_WINDOW: window_reg <= cfg_data[TIME_W-1:0];
                    default:           ;
                endcase
            end
            if (cmd.wr_kind == WR_NEW)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            if (cmd.load_in)
            begin
                addr_reg <= '0;
            end
            else if (cmd.rd_issue)
            begin
                addr_reg <= addr_reg + CNT_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mac_reg  <= source_mac;
            len_reg  <= frame_length;
            time_reg <= time_ns;
        end
        if (cmd.rd_issue)
        begin
            rd_addr_reg <= addr_reg[ADDR_W-1:0];
        end
        if (cmd.cap_hit)
        begin
            hit_addr_reg <= rd_addr_reg;
            tokens_reg   <= rd_entry.tokens;
            stamp_reg    <= rd_entry.stamp;
            // wrapping 64-bit difference
            elapsed_reg  <= time_reg - rd_entry.stamp;
        end
        if (cmd.set_res)
        begin
            res_pass_reg    <= cmd.res_pass;
            res_outcome_reg <= cmd.res_outcome;
        end
        if (cmd.out_load)
        begin
            out_pass_reg    <= res_pass_reg;
            out_outcome_reg <= res_outcome_reg;
        end
    end
endmodule

[sv/per_source_mac_rate_limiter_core.sv]
`timescale 1ns / 1ps
// per-source mac token bucket rate limiter, top level
// depends on psmrl_pkg, the channel interfaces, psmrl_ctrl and psmrl_dp
//
// usage:
//   frame   : one request per frame (source_mac, frame_length, time_ns)
//   verdict : one result per request (pass_frame, outcome), in order
//   cfg     : register writes, index 0 bucket_size, index 1 refill_window_ns;
//             always ready, write only while no request is in flight
// a request makes k entry ram reads between accept and verdict valid, where k
// is the position of the matching entry plus one, or the number of entries in
// use when the mac is new. the single read port of the entry ram scans one
// entry per cycle, so the worst case is TABLE_ENTRIES reads. a frame below 14
// bytes does not touch the table. one request is in flight at a time; the next
// is accepted the cycle after the verdict is loaded.
// reset empties the table at once (fill count to zero, no clearing pass),
// restores bucket_size 10 and refill_window_ns 5e9, and drops any verdict.
// when the receiver stalls, the verdict register holds; one more request can
// be accepted and worked, then the block waits before writing its verdict.

module per_source_mac_rate_limiter_core (
    input  logic          clk,
    input  logic          rst_n,
    psmrl_in_if.sink      frame,
    psmrl_out_if.source   verdict,
    psmrl_cfg_if.sink     cfg
);
    import psmrl_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    assign cfg.ready = 1'b1;

    psmrl_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame.valid),
        .frame_ready (frame.ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    psmrl_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .source_mac     (frame.source_mac),
        .frame_length   (frame.frame_length),
        .time_ns        (frame.time_ns),
        .out_valid      (verdict.valid),
        .out_ready      (verdict.ready),
        .out_pass_frame (verdict.pass_frame),
        .out_outcome    (verdict.outcome)
    );

    // a request is taken only when the controller loads it
    assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && frame.ready) |-> cmd.load_in)
        else $error("request accepted without load");

    // short frames never modify the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_kind != WR_NONE) |-> !sts.short_frame)
        else $error("table write for a short frame");

    // a new entry is only written while a slot is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_kind == WR_NEW) |-> !sts.table_full)
        else $error("new entry written into a full table");

    // the verdict register is never overwritten while it still holds a result
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!verdict.valid || verdict.ready))
        else $error("verdict overwritten while stalled");
endmodule
